// ===== design/ubd_pkg.sv =====
`timescale 1ns / 1ps

package ubd_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int MAX_SYMBOLS = 16;
    localparam int IN_W        = 64;
    localparam int DIGIT_W     = 4;
    localparam int BASE_W      = 5;
    localparam int SYM_W       = 8;
    localparam int SYMTAB_W    = 16 * SYM_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam int MAX_DIGITS  = VALUE_BITS;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int STACK_W     = MAX_DIGITS * DIGIT_W;

    // long division works through one byte of the dividend per cycle
    localparam int STEP_BITS   = 8;
    localparam int STEPS       = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int WORK_W      = STEPS * STEP_BITS;
    localparam int STEP_CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam logic [BASE_W-1:0]     BASE_RESET  = BASE_W'(10);
    localparam logic [CFG_DATA_W-1:0] SYMLO_RESET = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] SYMHI_RESET = 64'h6665646362613938;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_SIZE    = 2'd0,
        CFG_SYMBOLS_LOW  = 2'd1,
        CFG_SYMBOLS_HIGH = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DIVIDE = 2'd1,
        ST_EMIT   = 2'd2
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic pop;
    } t_dp_cmd;

    typedef struct packed {
        logic step_last;
        logic quot_zero;
        logic count_full;
        logic stack_last;
        logic out_free;
    } t_dp_stat;

    // clamp the configured radix into the supported range
    function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (r < BASE_W'(2)) r = BASE_W'(2);
        if (r > BASE_W'(MAX_SYMBOLS)) r = BASE_W'(MAX_SYMBOLS);
        return r;
    endfunction

endpackage

// ===== design/ubd_ctrl.sv =====
`timescale 1ns / 1ps

module ubd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_value_valid,
    output logic              o_value_ready,
    output ubd_pkg::t_dp_cmd  o_cmd,
    input  ubd_pkg::t_dp_stat i_stat
);
    import ubd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_value_valid) n_state = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (i_stat.step_last && (i_stat.quot_zero || i_stat.count_full))
                    n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free && i_stat.stack_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_value_ready  = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_value_ready = 1'b1;
                o_cmd.load    = i_value_valid;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.pop = i_stat.out_free;
            end
            default: begin
                o_value_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/ubd_datapath.sv =====
`timescale 1ns / 1ps

module ubd_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ubd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ubd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [ubd_pkg::IN_W-1:0]         i_value,
    input  ubd_pkg::t_dp_cmd                 i_cmd,
    output ubd_pkg::t_dp_stat                o_stat,
    output logic                             o_digit_valid,
    input  logic                             i_digit_ready,
    output logic [ubd_pkg::SYM_W-1:0]        o_digit_char,
    output logic                             o_final_digit
);
    import ubd_pkg::*;

    // configuration
    logic [BASE_W-1:0]     r_base_size;
    logic [CFG_DATA_W-1:0] r_sym_low;
    logic [CFG_DATA_W-1:0] r_sym_high;

    // division and digit stack
    logic [WORK_W-1:0]     r_work;
    logic [DIGIT_W-1:0]    r_rem;
    logic [STEP_CNT_W-1:0] r_step;
    logic [STACK_W-1:0]    r_stack;
    logic [CNT_W-1:0]      r_count;

    // output register
    logic                  r_out_valid;
    logic [SYM_W-1:0]      r_digit_char;
    logic                  r_final;

    logic [BASE_W-1:0]     base_eff;
    logic [BASE_W-1:0]     trial;
    logic [DIGIT_W-1:0]    rem_v;
    logic [STEP_BITS-1:0]  qbits;
    logic [WORK_W-1:0]     n_work;
    logic [SYMTAB_W-1:0]   symtab;
    logic [DIGIT_W-1:0]    top_digit;
    logic [SYM_W-1:0]      top_sym;
    logic                  step_last;

    assign base_eff = eff_base(r_base_size);

    // one byte of restoring division, remainder stays below the base
    always_comb begin
        rem_v = r_rem;
        trial = '0;
        qbits = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {rem_v, r_work[WORK_W-1-i]};
            if (trial >= base_eff) begin
                qbits[STEP_BITS-1-i] = 1'b1;
                trial = trial - base_eff;
            end
            rem_v = trial[DIGIT_W-1:0];
        end
        n_work = (r_work << STEP_BITS) | WORK_W'(qbits);
    end

    assign step_last = (r_step == STEP_CNT_W'(STEPS - 1));
    assign symtab    = {r_sym_high, r_sym_low};
    assign top_digit = r_stack[DIGIT_W-1:0];
    assign top_sym   = symtab[{top_digit, 3'b000} +: SYM_W];

    assign o_stat.step_last  = step_last;
    assign o_stat.quot_zero  = (n_work == '0);
    assign o_stat.count_full = (r_count == CNT_W'(MAX_DIGITS - 1));
    assign o_stat.stack_last = (r_count == CNT_W'(1));
    assign o_stat.out_free   = !r_out_valid || i_digit_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_size <= BASE_RESET;
            r_sym_low   <= SYMLO_RESET;
            r_sym_high  <= SYMHI_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_SIZE:    r_base_size <= i_cfg_data[BASE_W-1:0];
                CFG_SYMBOLS_LOW:  r_sym_low   <= i_cfg_data;
                CFG_SYMBOLS_HIGH: r_sym_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_step  <= '0;
                r_count <= '0;
            end else if (i_cmd.div_step) begin
                if (step_last) begin
                    r_step  <= '0;
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_step  <= r_step + STEP_CNT_W'(1);
                end
            end else if (i_cmd.pop) begin
                r_count <= r_count - CNT_W'(1);
            end

            if (i_cmd.pop) begin
                r_out_valid <= 1'b1;
            end else if (i_digit_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work <= WORK_W'(i_value[VALUE_BITS-1:0]);
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_work <= n_work;
            if (step_last) begin
                r_rem   <= '0;
                r_stack <= {r_stack[STACK_W-DIGIT_W-1:0], rem_v};
            end else begin
                r_rem   <= rem_v;
            end
        end else if (i_cmd.pop) begin
            r_stack <= r_stack >> DIGIT_W;
        end

        if (i_cmd.pop) begin
            r_digit_char <= top_sym;
            r_final      <= (r_count == CNT_W'(1));
        end
    end

    assign o_digit_valid = r_out_valid;
    assign o_digit_char  = r_digit_char;
    assign o_final_digit = r_final;

endmodule

// ===== design/unsigned_to_base_digits_core.sv =====
`timescale 1ns / 1ps
// byte-wise long division per digit (one byte of the 64-bit value per cycle through a shared
// divide unit), then digits are popped from the stack into the output register while the
// output side is free
// one item converted at a time; the last digit may still wait while the next item is taken
// reset: synchronous active low, restores radix 10 and symbols "0123456789abcdef"

module unsigned_to_base_digits_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [ubd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ubd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input item
    input  logic                           i_value_valid,
    output logic                           o_value_ready,
    input  logic [ubd_pkg::IN_W-1:0]       i_value,
    // result items, one per digit, most significant first
    output logic                           o_digit_valid,
    input  logic                           i_digit_ready,
    output logic [ubd_pkg::SYM_W-1:0]      o_digit_char,
    output logic                           o_final_digit
);
    import ubd_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: idle -> divide (one byte per cycle, digit pushed after the last byte step)
    // -> emit (digits popped lifo into the output register)
    ubd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_valid (i_value_valid),
        .o_value_ready (o_value_ready),
        .o_cmd         (dp_cmd),
        .i_stat        (dp_stat)
    );

    // divider, digit stack, symbol table and output register
    ubd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_value       (i_value),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_digit_valid (o_digit_valid),
        .i_digit_ready (i_digit_ready),
        .o_digit_char  (o_digit_char),
        .o_final_digit (o_final_digit)
    );

endmodule

// ===== design/ubd_checker.sv =====
`timescale 1ns / 1ps

module ubd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_value_valid,
    input logic                      o_value_ready,
    input logic                      o_digit_valid,
    input logic                      i_digit_ready,
    input logic [ubd_pkg::SYM_W-1:0] o_digit_char,
    input logic                      o_final_digit
);
    import ubd_pkg::*;

    // a stalled digit holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid && !i_digit_ready |=>
            o_digit_valid && $stable(o_digit_char) && $stable(o_final_digit))
        else $error("stalled digit changed");

    // conversion keeps the input closed after an item is accepted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_value_valid && o_value_ready |=> !o_value_ready ##1 !o_value_ready)
        else $error("input reopened too early");

    // digits of one run follow each other without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid && i_digit_ready && !o_final_digit |=> o_digit_valid)
        else $error("gap inside a digit run");

    // input reopens only as the final digit is loaded
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_value_ready) |-> o_digit_valid && o_final_digit)
        else $error("input reopened before final digit");

endmodule

bind unsigned_to_base_digits_core ubd_checker u_ubd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_value_valid (i_value_valid),
    .o_value_ready (o_value_ready),
    .o_digit_valid (o_digit_valid),
    .i_digit_ready (i_digit_ready),
    .o_digit_char  (o_digit_char),
    .o_final_digit (o_final_digit)
);
